[hw/rtl/fps_pkg.sv]
// Package for the flight phase sequencer: phase, event and request codes,
// register map, configuration struct and the event transition table.
// Used by fps_regs, fps_core and flight_phase_sequencer.
package fps_pkg;

	localparam int unsigned PHASE_W   = 4;
	localparam int unsigned EVENT_W   = 4;
	localparam int unsigned ELAPSED_W = 24;
	localparam int unsigned APB_AW    = 5;
	localparam int unsigned APB_DW    = 32;

	localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;

	// flight phases
	localparam logic [PHASE_W-1:0] PH_ABORT     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_STARTUP   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_INIT      = 4'd2;
	localparam logic [PHASE_W-1:0] PH_ALIGN     = 4'd3;
	localparam logic [PHASE_W-1:0] PH_CHECKOUTS = 4'd4;
	localparam logic [PHASE_W-1:0] PH_ARMED     = 4'd5;
	localparam logic [PHASE_W-1:0] PH_BURN      = 4'd6;
	localparam logic [PHASE_W-1:0] PH_COAST     = 4'd7;
	localparam logic [PHASE_W-1:0] PH_FREE_FALL = 4'd8;
	localparam logic [PHASE_W-1:0] PH_DROGUE    = 4'd9;
	localparam logic [PHASE_W-1:0] PH_MAIN      = 4'd10;
	localparam logic [PHASE_W-1:0] PH_LANDED    = 4'd11;
	localparam logic [PHASE_W-1:0] PH_TEST      = 4'd12;
	localparam logic [PHASE_W-1:0] PH_CALIB     = 4'd13;
	localparam logic [PHASE_W-1:0] PH_COUNT     = 4'd14;

	// events
	localparam logic [EVENT_W-1:0] EV_STARTUP_DONE = 4'd0;
	localparam logic [EVENT_W-1:0] EV_ABORT        = 4'd1;
	localparam logic [EVENT_W-1:0] EV_GNSS_FIX     = 4'd2;
	localparam logic [EVENT_W-1:0] EV_TEST_ENTER   = 4'd3;
	localparam logic [EVENT_W-1:0] EV_CONVERGED    = 4'd4;
	localparam logic [EVENT_W-1:0] EV_CHECKOUTS    = 4'd5;
	localparam logic [EVENT_W-1:0] EV_LAUNCH       = 4'd6;
	localparam logic [EVENT_W-1:0] EV_BURNOUT      = 4'd7;
	localparam logic [EVENT_W-1:0] EV_APOGEE       = 4'd8;
	localparam logic [EVENT_W-1:0] EV_DROGUE       = 4'd9;
	localparam logic [EVENT_W-1:0] EV_MAIN         = 4'd10;
	localparam logic [EVENT_W-1:0] EV_TOUCHDOWN    = 4'd11;
	localparam logic [EVENT_W-1:0] EV_CALIBRATE    = 4'd12;
	localparam logic [EVENT_W-1:0] EV_TEST_EXIT    = 4'd13;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_EVENT   = 2'd1,
		REQ_FORCE   = 2'd2,
		REQ_RESTART = 2'd3
	} fps_req_t;

	typedef enum logic [2:0] {
		REG_DWELL_CONVERGED = 3'd0,
		REG_DWELL_CHECKOUTS = 3'd1,
		REG_DWELL_LAUNCH    = 3'd2,
		REG_DWELL_BURNOUT   = 3'd3,
		REG_DWELL_APOGEE    = 3'd4,
		REG_DWELL_TOUCHDOWN = 3'd5,
		REG_START_PHASE     = 3'd6
	} fps_reg_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0] dwell_converged;
		logic [ELAPSED_W-1:0] dwell_checkouts;
		logic [ELAPSED_W-1:0] dwell_launch;
		logic [ELAPSED_W-1:0] dwell_burnout;
		logic [ELAPSED_W-1:0] dwell_apogee;
		logic [ELAPSED_W-1:0] dwell_touchdown;
		logic [PHASE_W-1:0]   start_phase;
	} fps_cfg_t;

	// Transition table; returns the current phase where the event has no edge.
	function automatic logic [PHASE_W-1:0] fps_next_phase(
		input logic [PHASE_W-1:0] ph,
		input logic [EVENT_W-1:0] ev
	);
		logic [PHASE_W-1:0] np;
		np = ph;
		case (ph)
			PH_STARTUP: begin
				if (ev == EV_STARTUP_DONE) np = PH_INIT;
			end
			PH_INIT: begin
				if (ev == EV_ABORT) np = PH_ABORT;
				else if (ev == EV_GNSS_FIX) np = PH_ALIGN;
				else if (ev == EV_TEST_ENTER) np = PH_TEST;
			end
			PH_ALIGN: begin
				if (ev == EV_ABORT) np = PH_ABORT;
				else if (ev == EV_CONVERGED) np = PH_CHECKOUTS;
			end
			PH_CHECKOUTS: begin
				if (ev == EV_ABORT) np = PH_ABORT;
				else if (ev == EV_CHECKOUTS) np = PH_ARMED;
			end
			PH_ARMED: begin
				if (ev == EV_ABORT) np = PH_ABORT;
				else if (ev == EV_LAUNCH) np = PH_BURN;
			end
			PH_BURN: begin
				if (ev == EV_ABORT) np = PH_ABORT;
				else if (ev == EV_BURNOUT) np = PH_COAST;
			end
			PH_COAST: begin
				if (ev == EV_ABORT) np = PH_ABORT;
				else if (ev == EV_APOGEE) np = PH_FREE_FALL;
			end
			PH_FREE_FALL: begin
				if (ev == EV_ABORT) np = PH_ABORT;
				else if (ev == EV_DROGUE) np = PH_DROGUE;
				else if (ev == EV_TOUCHDOWN) np = PH_LANDED;
			end
			PH_DROGUE: begin
				if (ev == EV_ABORT) np = PH_ABORT;
				else if (ev == EV_MAIN) np = PH_MAIN;
				else if (ev == EV_TOUCHDOWN) np = PH_LANDED;
			end
			PH_MAIN: begin
				if (ev == EV_TOUCHDOWN) np = PH_LANDED;
			end
			PH_TEST: begin
				if (ev == EV_CALIBRATE) np = PH_CALIB;
				else if (ev == EV_TEST_EXIT) np = PH_INIT;
			end
			PH_CALIB: begin
				if (ev == EV_TEST_EXIT) np = PH_INIT;
			end
			default: np = ph;
		endcase
		return np;
	endfunction

endpackage

[hw/rtl/fps_regs.sv]
// Configuration register bank of the flight phase sequencer, APB-style port.
// Depends on fps_pkg for the register map and the configuration struct.
module fps_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fps_pkg::APB_AW-1:0] paddr,
	input  logic [fps_pkg::APB_DW-1:0] pwdata,
	output logic [fps_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output fps_pkg::fps_cfg_t          cfg
);
	import fps_pkg::*;

	fps_cfg_t cfg_q;
	fps_reg_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = fps_reg_t'(paddr[APB_AW-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dwell_converged <= '0;
			cfg_q.dwell_checkouts <= '0;
			cfg_q.dwell_launch    <= '0;
			cfg_q.dwell_burnout   <= '0;
			cfg_q.dwell_apogee    <= '0;
			cfg_q.dwell_touchdown <= '0;
			cfg_q.start_phase     <= PH_STARTUP;
		end else if (wr_en) begin
			case (reg_sel)
				REG_DWELL_CONVERGED: cfg_q.dwell_converged <= pwdata[ELAPSED_W-1:0];
				REG_DWELL_CHECKOUTS: cfg_q.dwell_checkouts <= pwdata[ELAPSED_W-1:0];
				REG_DWELL_LAUNCH:    cfg_q.dwell_launch    <= pwdata[ELAPSED_W-1:0];
				REG_DWELL_BURNOUT:   cfg_q.dwell_burnout   <= pwdata[ELAPSED_W-1:0];
				REG_DWELL_APOGEE:    cfg_q.dwell_apogee    <= pwdata[ELAPSED_W-1:0];
				REG_DWELL_TOUCHDOWN: cfg_q.dwell_touchdown <= pwdata[ELAPSED_W-1:0];
				REG_START_PHASE:     cfg_q.start_phase     <= pwdata[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_DWELL_CONVERGED: prdata = APB_DW'(cfg_q.dwell_converged);
			REG_DWELL_CHECKOUTS: prdata = APB_DW'(cfg_q.dwell_checkouts);
			REG_DWELL_LAUNCH:    prdata = APB_DW'(cfg_q.dwell_launch);
			REG_DWELL_BURNOUT:   prdata = APB_DW'(cfg_q.dwell_burnout);
			REG_DWELL_APOGEE:    prdata = APB_DW'(cfg_q.dwell_apogee);
			REG_DWELL_TOUCHDOWN: prdata = APB_DW'(cfg_q.dwell_touchdown);
			REG_START_PHASE:     prdata = APB_DW'(cfg_q.start_phase);
			default:             prdata = '0;
		endcase
	end

endmodule

[hw/rtl/fps_core.sv]
// Sequencer datapath: input register, phase and elapsed state, result register.
// Depends on fps_pkg for codes, the configuration struct and the transition table.
module fps_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fps_pkg::fps_cfg_t             cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [fps_pkg::EVENT_W-1:0]   event_code,
	input  logic [fps_pkg::PHASE_W-1:0]   target_phase,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fps_pkg::PHASE_W-1:0]   phase,
	output logic                          phase_changed,
	output logic                          dwell_blocked,
	output logic                          deadline_armed
);
	import fps_pkg::*;

	// input stage
	logic                 valid_s1;
	fps_req_t             req_s1;
	logic [EVENT_W-1:0]   event_s1;
	logic [PHASE_W-1:0]   target_s1;

	// result stage
	logic                 valid_s2;
	logic [PHASE_W-1:0]   phase_s2;
	logic                 changed_s2;
	logic                 blocked_s2;
	logic                 armed_s2;

	// sequencer state
	logic [PHASE_W-1:0]   flight_phase_q;
	logic [ELAPSED_W-1:0] elapsed_q;

	logic                 advance;
	logic [PHASE_W-1:0]   nxt_phase;
	logic [ELAPSED_W-1:0] nxt_elapsed;
	logic                 nxt_changed;
	logic                 nxt_blocked;
	logic [PHASE_W-1:0]   ev_phase;
	logic [PHASE_W-1:0]   start_ph;
	logic [ELAPSED_W-1:0] min_dwell;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1    <= fps_req_t'(req_type);
			event_s1  <= event_code;
			target_s1 <= target_phase;
		end
	end

	assign ev_phase = fps_next_phase(flight_phase_q, event_s1);
	assign start_ph = (cfg.start_phase < PH_COUNT) ? cfg.start_phase : PH_STARTUP;

	always_comb begin
		case (event_s1)
			EV_CONVERGED: min_dwell = cfg.dwell_converged;
			EV_CHECKOUTS: min_dwell = cfg.dwell_checkouts;
			EV_LAUNCH:    min_dwell = cfg.dwell_launch;
			EV_BURNOUT:   min_dwell = cfg.dwell_burnout;
			EV_APOGEE:    min_dwell = cfg.dwell_apogee;
			EV_TOUCHDOWN: min_dwell = cfg.dwell_touchdown;
			default:      min_dwell = '0;
		endcase
	end

	always_comb begin
		nxt_phase   = flight_phase_q;
		nxt_elapsed = elapsed_q;
		nxt_changed = 1'b0;
		nxt_blocked = 1'b0;
		case (req_s1)
			REQ_TICK: begin
				// saturate at the top of the count
				if (elapsed_q != ELAPSED_TOP) nxt_elapsed = elapsed_q + 1'b1;
			end
			REQ_EVENT: begin
				if (ev_phase != flight_phase_q) begin
					if (min_dwell > elapsed_q) begin
						nxt_blocked = 1'b1;
					end else begin
						nxt_phase   = ev_phase;
						nxt_elapsed = '0;
						nxt_changed = 1'b1;
					end
				end
			end
			REQ_FORCE: begin
				if (target_s1 != flight_phase_q && target_s1 < PH_COUNT) begin
					nxt_phase   = target_s1;
					nxt_elapsed = '0;
					nxt_changed = 1'b1;
				end
			end
			REQ_RESTART: begin
				// clear elapsed even when the phase stays
				nxt_phase   = start_ph;
				nxt_elapsed = '0;
				nxt_changed = (start_ph != flight_phase_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_phase_q <= PH_STARTUP;
			elapsed_q      <= '0;
			valid_s2       <= 1'b0;
		end else begin
			if (advance) begin
				flight_phase_q <= nxt_phase;
				elapsed_q      <= nxt_elapsed;
			end
			if (advance) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_s2   <= nxt_phase;
			changed_s2 <= nxt_changed;
			blocked_s2 <= nxt_blocked;
			armed_s2   <= nxt_phase inside {[PH_BURN:PH_MAIN]};
		end
	end

	assign out_valid      = valid_s2;
	assign phase          = phase_s2;
	assign phase_changed  = changed_s2;
	assign dwell_blocked  = blocked_s2;
	assign deadline_armed = armed_s2;

	// the shown result always reflects the held state
	a_phase_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> phase_s2 == flight_phase_q)
		else $error("result phase differs from held phase");

	a_change_clears_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && changed_s2 |-> elapsed_q == '0)
		else $error("elapsed count not cleared on a phase change");

	a_blocked_not_changed: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && blocked_s2 |-> !changed_s2 && $stable(flight_phase_q))
		else $error("blocked item changed the phase");

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		flight_phase_q < PH_COUNT)
		else $error("flight phase out of range");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(flight_phase_q) && $stable(elapsed_q))
		else $error("state moved without an item");

endmodule

[hw/rtl/flight_phase_sequencer.sv]
// Flight phase sequencer top level: configuration bank and sequencer core.
// An accepted item goes through the input register, then the result register.
// Throughput: one item per cycle while out_ready does not stall the result;
// the phase/elapsed update is a single combinational pass between the two.
// Reset: phase startup, elapsed 0, all dwells 0, start phase startup.
// Depends on fps_pkg, fps_regs and fps_core.
module flight_phase_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fps_pkg::APB_AW-1:0]    paddr,
	input  logic [fps_pkg::APB_DW-1:0]    pwdata,
	output logic [fps_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [fps_pkg::EVENT_W-1:0]   event_code,
	input  logic [fps_pkg::PHASE_W-1:0]   target_phase,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fps_pkg::PHASE_W-1:0]   phase,
	output logic                          phase_changed,
	output logic                          dwell_blocked,
	output logic                          deadline_armed
);
	import fps_pkg::*;

	fps_cfg_t cfg;

	fps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fps_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.event_code     (event_code),
		.target_phase   (target_phase),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.phase          (phase),
		.phase_changed  (phase_changed),
		.dwell_blocked  (dwell_blocked),
		.deadline_armed (deadline_armed)
	);

endmodule
